/* rtl/core/gcm_pkg.sv */
// Shared types and constants for the greedy corner matcher.
// Holds word structs, controller states and the controller/datapath link.
// No dependencies.
package gcm_pkg;

    localparam int MAX_POINTS  = 16;
    localparam int NUM_CORNERS = 4;
    localparam int COORD_W     = 16;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int SCAN_W      = $clog2(MAX_POINTS + 2);
    localparam int CORNER_W    = $clog2(NUM_CORNERS);
    localparam int EXP_W       = 9;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEST_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPAND = 2'd2;

    localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(NUM_CORNERS - 1);

    typedef struct packed {
        logic [COORD_W-1:0] found_x;
        logic [COORD_W-1:0] found_y;
        logic               last_point;
    } t_in_word;

    typedef struct packed {
        logic [CORNER_W-1:0] corner_index;
        logic [COORD_W-1:0]  out_x;
        logic [COORD_W-1:0]  out_y;
        logic                matched;
        logic                last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_point;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BLEND_X,
        ST_BLEND_Y,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                load;
        logic                scan_clear;
        logic                issue;
        logic [IDX_W-1:0]    addr;
        logic                blend_x;
        logic                blend_y;
        logic                emit;
        logic [CORNER_W-1:0] corner;
        logic                last;
    } t_dp_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] point_count;
    } t_dp_status;

endpackage

/* rtl/core/gcm_ctrl.sv */
// Controller for the greedy corner matcher: load, scan, blend and emit sequence.
// Depends on gcm_pkg.
module gcm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_last_point,
    input  gcm_pkg::t_dp_status i_status,
    output logic               o_busy,
    output gcm_pkg::t_dp_cmd   o_cmd
);
    import gcm_pkg::*;

    t_state              r_state, n_state;
    logic [SCAN_W-1:0]   r_cnt, n_cnt;
    logic [CORNER_W-1:0] r_corner, n_corner;
    logic [SCAN_W-1:0]   w_count;
    logic                w_scan_end;
    logic                w_accept;

    assign w_count    = SCAN_W'(i_status.point_count);
    assign w_scan_end = (r_cnt == w_count + SCAN_W'(2));
    assign w_accept   = i_start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_last_point) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_scan_end) n_state = ST_BLEND_X;
            end
            ST_BLEND_X: n_state = ST_BLEND_Y;
            ST_BLEND_Y: n_state = ST_EMIT;
            ST_EMIT: begin
                n_state = (r_corner == LAST_CORNER) ? ST_IDLE : ST_SCAN;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_corner = r_corner;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt    = '0;
                n_corner = '0;
            end
            ST_SCAN:    n_cnt = r_cnt + SCAN_W'(1);
            ST_EMIT: begin
                n_cnt    = '0;
                n_corner = r_corner + CORNER_W'(1);
            end
            default: ;
        endcase
    end

    always_comb begin
        o_busy           = (r_state != ST_IDLE);
        o_cmd            = '0;
        o_cmd.corner     = r_corner;
        o_cmd.last       = (r_corner == LAST_CORNER);
        o_cmd.addr       = r_cnt[IDX_W-1:0];
        o_cmd.load       = w_accept;
        o_cmd.scan_clear = (r_state == ST_SCAN) && (r_cnt == '0);
        o_cmd.issue      = (r_state == ST_SCAN) && (r_cnt < w_count);
        o_cmd.blend_x    = (r_state == ST_BLEND_X);
        o_cmd.blend_y    = (r_state == ST_BLEND_Y);
        o_cmd.emit       = (r_state == ST_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_corner <= n_corner;
        end
    end

endmodule

/* rtl/core/gcm_dp.sv */
// Datapath for the greedy corner matcher: config registers, point store,
// distance pipeline, best-point tracking, blend unit and output register.
// Depends on gcm_pkg.
module gcm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gcm_pkg::t_in_word             i_in,
    input  logic                          i_cfg_we,
    input  logic [gcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gcm_pkg::CFG_W-1:0]     i_cfg_data,
    input  gcm_pkg::t_dp_cmd              i_cmd,
    output gcm_pkg::t_dp_status           o_status,
    output logic                          o_out_valid,
    output gcm_pkg::t_out_word            o_out
);
    import gcm_pkg::*;

    localparam int PROD_W = COORD_W + EXP_W + 2;
    localparam int DIST_W = 2 * COORD_W + 1;

    logic [CFG_W-1:0]      r_dest_x, r_dest_y;
    logic [EXP_W-1:0]      r_expand;

    t_point                r_store [MAX_POINTS];
    t_point                r_rd;
    logic [CNT_W-1:0]      r_point_count;
    logic [MAX_POINTS-1:0] r_used;

    logic                  r_v1, r_v2;
    logic [IDX_W-1:0]      r_j1, r_j2;
    t_point                r_p2;
    logic [2*COORD_W-1:0]  r_sq_x, r_sq_y;

    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx;
    t_point                r_best;
    logic [DIST_W-1:0]     r_best_dist;

    logic signed [PROD_W-1:0] r_prod;
    logic [COORD_W-1:0]    r_res_x;
    t_out_word             r_out;
    logic                  r_out_valid;

    logic [COORD_W-1:0]    w_dx, w_dy, w_ax, w_ay;
    logic [DIST_W-1:0]     w_dist;
    logic                  w_take;
    logic signed [COORD_W:0] w_diff;
    logic [COORD_W-1:0]    w_base;
    logic signed [PROD_W-1:0] w_mul;

    function automatic logic [COORD_W-1:0] sat_blend(
        input logic [COORD_W-1:0]      p,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W:0] s;
        s = $signed({{(PROD_W - COORD_W - 7){1'b0}}, p, 8'd0}) + (PROD_W + 1)'(prod);
        if (s[PROD_W])
            return '0;
        else if (|s[PROD_W-1:COORD_W+8])
            return '1;
        else
            return s[COORD_W+7:8];
    endfunction

    assign w_dx = r_dest_x[COORD_W*i_cmd.corner +: COORD_W];
    assign w_dy = r_dest_y[COORD_W*i_cmd.corner +: COORD_W];
    assign w_ax = (r_rd.x >= w_dx) ? (r_rd.x - w_dx) : (w_dx - r_rd.x);
    assign w_ay = (r_rd.y >= w_dy) ? (r_rd.y - w_dy) : (w_dy - r_rd.y);
    assign w_dist = DIST_W'(r_sq_x) + DIST_W'(r_sq_y);
    assign w_take = r_v2 && (!r_found || (w_dist < r_best_dist));

    // one shared multiplier: e * (d - p), x then y
    assign w_base = i_cmd.blend_x ? r_best.x : r_best.y;
    assign w_diff = i_cmd.blend_x ? ($signed({1'b0, w_dx}) - $signed({1'b0, r_best.x}))
                                  : ($signed({1'b0, w_dy}) - $signed({1'b0, r_best.y}));
    assign w_mul  = PROD_W'($signed({1'b0, r_expand}) * w_diff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_point_count < CNT_W'(MAX_POINTS))) begin
            r_store[r_point_count[IDX_W-1:0]] <= '{x: i_in.found_x, y: i_in.found_y};
        end
        r_rd <= r_store[i_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_x      <= '0;
            r_dest_y      <= '0;
            r_expand      <= '0;
            r_point_count <= '0;
            r_used        <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_DEST_X: r_dest_x <= i_cfg_data;
                    REG_DEST_Y: r_dest_y <= i_cfg_data;
                    REG_EXPAND: r_expand <= i_cfg_data[EXP_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load && (r_point_count < CNT_W'(MAX_POINTS)))
                r_point_count <= r_point_count + CNT_W'(1);
            r_v1 <= i_cmd.issue && !r_used[i_cmd.addr];
            r_v2 <= r_v1;
            if (i_cmd.scan_clear)
                r_found <= 1'b0;
            else if (w_take)
                r_found <= 1'b1;
            r_out_valid <= i_cmd.emit;
            if (i_cmd.emit) begin
                if (i_cmd.last) begin
                    r_used        <= '0;
                    r_point_count <= '0;
                end else if (r_found) begin
                    r_used[r_best_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j1   <= i_cmd.addr;
        r_j2   <= r_j1;
        r_p2   <= r_rd;
        r_sq_x <= w_ax * w_ax;
        r_sq_y <= w_ay * w_ay;
        if (w_take) begin
            r_best_idx  <= r_j2;
            r_best      <= r_p2;
            r_best_dist <= w_dist;
        end
        if (i_cmd.blend_x || i_cmd.blend_y)
            r_prod <= w_mul;
        if (i_cmd.blend_y)
            r_res_x <= sat_blend(r_best.x, r_prod);
        if (i_cmd.emit) begin
            r_out.corner_index <= i_cmd.corner;
            r_out.matched      <= r_found;
            r_out.last_of_run  <= i_cmd.last;
            r_out.out_x        <= r_found ? r_res_x : w_dx;
            r_out.out_y        <= r_found ? sat_blend(r_best.y, r_prod) : w_dy;
        end
    end

    assign o_status.point_count = r_point_count;
    assign o_out_valid          = r_out_valid;
    assign o_out                = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_point_count <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");

    a_used_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) <= int'(r_point_count))
        else $error("more used marks than stored points");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobes back to back");

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last_of_run |-> (r_point_count == '0) && (r_used == '0))
        else $error("run state not cleared after final word");

endmodule

/* rtl/core/greedy_corner_matcher.sv */
// Top level of the greedy corner matcher: controller plus datapath.
// Depends on gcm_pkg, gcm_ctrl, gcm_dp.
//
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+---------------------------
// input    | i_in (found_x, found_y, last_point)     | i_start && !o_busy
// result   | o_out (corner_index, out_x, out_y, ...) | o_out_valid, one cycle
// config   | i_cfg_index, i_cfg_data                 | i_cfg_we
//
// A point word without last_point is taken while o_busy stays low. A word with last_point
// starts a run that, per corner, reads the N stored points from the store, drains them
// through read, square and compare, blends x then y and emits one word; o_busy is high
// throughout and the last word strobes as o_busy falls.
// Reset is synchronous, active low, and empties the store.
// Results are strobed for one cycle; the receiver cannot stall.
module greedy_corner_matcher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  gcm_pkg::t_in_word             i_in,
    output logic                          o_out_valid,
    output gcm_pkg::t_out_word            o_out,
    input  logic                          i_cfg_we,
    input  logic [gcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gcm_pkg::CFG_W-1:0]     i_cfg_data
);
    import gcm_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    gcm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_last_point (i_in.last_point),
        .i_status     (w_status),
        .o_busy       (o_busy),
        .o_cmd        (w_cmd)
    );

    gcm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

/* sim/tb_greedy_corner_matcher.sv */
// Self-checking testbench for greedy_corner_matcher: point words in, four corners out.
// Holds its own matcher model, a queue-fed driver and a strobe monitor.
// Depends on gcm_pkg and greedy_corner_matcher.
`timescale 1ns / 1ps

module tb_greedy_corner_matcher;
    import gcm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int TARGET_WORDS = 460;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_start     = 1'b0;
    t_in_word             i_in        = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 o_busy;
    logic                 o_out_valid;
    t_out_word            o_out;

    greedy_corner_matcher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the block's registers and point store
    logic [CFG_W-1:0]   dest_x_cfg = '0;
    logic [CFG_W-1:0]   dest_y_cfg = '0;
    logic [EXP_W-1:0]   expand_cfg = '0;
    logic [COORD_W-1:0] store_x [MAX_POINTS];
    logic [COORD_W-1:0] store_y [MAX_POINTS];
    logic [MAX_POINTS-1:0] taken_mask = '0;
    int                 n_stored = 0;

    t_in_word  point_fifo [$];
    t_out_word want_corners [$];

    logic steady = 1'b0;
    int   n_queued = 0;
    int   n_words = 0;
    int   n_runs = 0;
    int   n_dropped = 0;
    int   n_writes = 0;
    int   n_results = 0;
    int   n_unmatched = 0;
    int   n_bad = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [COORD_W-1:0] pull_coord(logic [COORD_W-1:0] p,
                                                      logic [COORD_W-1:0] d,
                                                      logic [EXP_W-1:0] e);
        longint v;
        v = (256 - longint'(e)) * longint'(p) + longint'(e) * longint'(d);
        if (v < 0)
            return '0;
        v = v >>> 8;
        if (v > 65535)
            return 16'hFFFF;
        return v[COORD_W-1:0];
    endfunction

    // store one point word; a last mark runs the greedy assignment
    task automatic take_point(input t_in_word w);
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        longint unsigned    sq_dist;
        longint unsigned    best_dist;
        longint             ddx;
        longint             ddy;
        int                 best;
        t_out_word          o;
        n_words++;
        if (n_stored < MAX_POINTS) begin
            store_x[n_stored] = w.found_x;
            store_y[n_stored] = w.found_y;
            taken_mask[n_stored] = 1'b0;
            n_stored++;
        end else begin
            n_dropped++;
        end
        if (!w.last_point)
            return;
        n_runs++;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            dx = dest_x_cfg[k*COORD_W +: COORD_W];
            dy = dest_y_cfg[k*COORD_W +: COORD_W];
            best = -1;
            best_dist = 0;
            for (int j = 0; j < n_stored; j++) begin
                if (!taken_mask[j]) begin
                    ddx = longint'(store_x[j]) - longint'(dx);
                    ddy = longint'(store_y[j]) - longint'(dy);
                    sq_dist = ddx * ddx + ddy * ddy;
                    if (best < 0 || sq_dist < best_dist) begin
                        best = j;
                        best_dist = sq_dist;
                    end
                end
            end
            o.corner_index = k[CORNER_W-1:0];
            o.last_of_run  = (o.corner_index == LAST_CORNER);
            if (best >= 0) begin
                taken_mask[best] = 1'b1;
                o.out_x   = pull_coord(store_x[best], dx, expand_cfg);
                o.out_y   = pull_coord(store_y[best], dy, expand_cfg);
                o.matched = 1'b1;
            end else begin
                o.out_x   = dx;
                o.out_y   = dy;
                o.matched = 1'b0;
            end
            want_corners = {want_corners, o};
        end
        n_stored = 0;
        taken_mask = '0;
    endtask

    always @(posedge i_clk) begin
        t_in_word junk;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy)
                take_point(i_in);
            if (i_start && o_busy) begin
                // held until the block takes it
            end else if (point_fifo.size() != 0 && (steady || $urandom_range(0, 99) >= 26)) begin
                i_start <= 1'b1;
                i_in    <= point_fifo.pop_front();
            end else begin
                junk.found_x    = COORD_W'($urandom);
                junk.found_y    = COORD_W'($urandom);
                junk.last_point = 1'($urandom_range(0, 1));
                i_start <= 1'b0;
                i_in    <= junk;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid) begin
            if (want_corners.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: unexpected word idx=%0d x=%h y=%h m=%b last=%b", $realtime,
                             o_out.corner_index, o_out.out_x, o_out.out_y, o_out.matched,
                             o_out.last_of_run);
            end else begin
                want = want_corners.pop_front();
                n_results++;
                if (!want.matched)
                    n_unmatched++;
                if (o_out.corner_index !== want.corner_index || o_out.out_x !== want.out_x ||
                    o_out.out_y !== want.out_y || o_out.matched !== want.matched ||
                    o_out.last_of_run !== want.last_of_run) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: mismatch exp idx=%0d x=%h y=%h m=%b last=%b | got idx=%0d x=%h y=%h m=%b last=%b",
                                 $realtime, want.corner_index, want.out_x, want.out_y,
                                 want.matched, want.last_of_run, o_out.corner_index,
                                 o_out.out_x, o_out.out_y, o_out.matched, o_out.last_of_run);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_DEST_X: dest_x_cfg = data;
            REG_DEST_Y: dest_y_cfg = data;
            REG_EXPAND: expand_cfg = data[EXP_W-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_point(input int x, input int y, input logic last);
        t_in_word w;
        w.found_x    = x[COORD_W-1:0];
        w.found_y    = y[COORD_W-1:0];
        w.last_point = last;
        point_fifo = {point_fifo, w};
        n_queued++;
    endtask

    task automatic drain();
        do
            @(negedge i_clk);
        while (point_fifo.size() != 0 || i_start || want_corners.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic int near_lane(logic [CFG_W-1:0] lanes, int k);
        int v;
        v = int'(lanes[k*COORD_W +: COORD_W]) + $urandom_range(0, 80) - 40;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_lanes();
        logic [CFG_W-1:0] lanes;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            case ($urandom_range(0, 4))
                0: lanes[k*COORD_W +: COORD_W] = 16'h0000;
                1: lanes[k*COORD_W +: COORD_W] = 16'hFFFF;
                2: lanes[k*COORD_W +: COORD_W] = COORD_W'($urandom_range(16'h0400, 16'h0C00));
                default: lanes[k*COORD_W +: COORD_W] = COORD_W'($urandom);
            endcase
        end
        return lanes;
    endfunction

    function automatic logic [CFG_W-1:0] pick_expand();
        logic [CFG_W-1:0] data;
        data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
        case ($urandom_range(0, 5))
            0: data[EXP_W-1:0] = 9'd0;
            1: data[EXP_W-1:0] = 9'd256;
            2: data[EXP_W-1:0] = 9'd511;
            3: data[EXP_W-1:0] = 9'd128;
            4: data[EXP_W-1:0] = EXP_W'($urandom_range(0, 256));
            default: data[EXP_W-1:0] = EXP_W'($urandom_range(257, 511));
        endcase
        return data;
    endfunction

    task automatic queue_run(input int len);
        int x;
        int y;
        int k;
        for (int i = 0; i < len; i++) begin
            k = $urandom_range(0, NUM_CORNERS - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    x = near_lane(dest_x_cfg, k);
                    y = near_lane(dest_y_cfg, k);
                end
                5, 6: begin
                    x = $urandom_range(0, 65535);
                    y = $urandom_range(0, 65535);
                end
                7: begin
                    x = $urandom_range(0, 1) ? 65535 : 0;
                    y = $urandom_range(0, 1) ? 65535 : 0;
                end
                default: begin
                    // repeat the previous point to force equal distances
                    if (point_fifo.size() != 0) begin
                        x = int'(point_fifo[$].found_x);
                        y = int'(point_fifo[$].found_y);
                    end else begin
                        x = near_lane(dest_x_cfg, k);
                        y = near_lane(dest_y_cfg, k);
                    end
                end
            endcase
            push_point(x, y, i == len - 1);
        end
    endtask

    initial begin
        int phase;
        int runs;
        int len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, equal-distance tie, short runs, saturation
        write_reg(REG_DEST_X, {16'h8000, 16'h1234, 16'hFFFF, 16'h0000});
        write_reg(REG_DEST_Y, {16'h0000, 16'h4321, 16'hFFFF, 16'h0000});
        write_reg(REG_EXPAND, 64'd0);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        end_writes();
        push_point(3, 4, 1'b0);
        push_point(16'hFFFF, 16'hFFFF, 1'b0);
        push_point(4, 3, 1'b0);
        push_point(16'h1234, 16'h4321, 1'b0);
        push_point(16'h8000, 16'h0000, 1'b1);
        push_point(16'h7FFF, 16'h8001, 1'b1);
        drain();
        write_reg(REG_EXPAND, 64'd256);
        end_writes();
        push_point(16'h0010, 16'h0020, 1'b0);
        push_point(16'hFFF0, 16'h0001, 1'b0);
        push_point(16'h5555, 16'hAAAA, 1'b1);
        drain();
        write_reg(REG_DEST_X, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
        write_reg(REG_DEST_Y, {16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000});
        write_reg(REG_EXPAND, 64'hABCD_0000_0000_01FF);
        end_writes();
        push_point(0, 0, 1'b0);
        push_point(16'hFFFF, 16'hFFFF, 1'b0);
        push_point(0, 16'hFFFF, 1'b0);
        push_point(16'hFFFF, 0, 1'b1);
        drain();

        phase = 0;
        while (n_queued < TARGET_WORDS) begin
            phase++;
            write_reg(REG_DEST_X, pick_lanes());
            write_reg(REG_DEST_Y, pick_lanes());
            write_reg(REG_EXPAND, pick_expand());
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, {$urandom, $urandom});
            end_writes();
            steady = (phase >= 4 && phase <= 7);
            runs = $urandom_range(2, 6);
            for (int r = 0; r < runs; r++) begin
                case ($urandom_range(0, 19))
                    0: len = $urandom_range(17, 22);
                    1, 2, 3: len = $urandom_range(9, 16);
                    default: len = $urandom_range(1, 8);
                endcase
                if (phase == 1 && r == 0)
                    len = 20;
                queue_run(len);
            end
            drain();
        end
        steady = 1'b0;
        repeat (20) @(posedge i_clk);

        $display("summary: %0d point words in %0d runs (%0d past capacity), %0d register writes",
                 n_words, n_runs, n_dropped, n_writes);
        $display("summary: %0d corners checked, %0d unmatched, %0d mismatches, %0d left over",
                 n_results, n_unmatched, n_bad, want_corners.size());
        if (n_bad == 0 && want_corners.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
